[hdl/rgbgb_pkg.sv]
`timescale 1ns / 1ps

package rgbgb_pkg;

	localparam int COL_W          = 8;
	localparam int ROW_W          = 10;
	localparam int CH_W           = 8;
	localparam int CH_COUNT       = 3;
	localparam int PIX_W          = CH_W * CH_COUNT;
	localparam int LINE_COUNT     = 3;
	localparam int ENTRY_W        = PIX_W * LINE_COUNT;
	localparam int IN_TDATA_W     = 48;
	localparam int OUT_TDATA_W    = 24;
	localparam int LINE_WIDTH_DEF = 256;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	// One blurred pixel handed from the front end to the result queue.
	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pixel;
	} blur_push_t;

endpackage

[hdl/rgbgb_ram.sv]
`timescale 1ns / 1ps

module rgbgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the contents from before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hdl/rgbgb_front.sv]
`timescale 1ns / 1ps

module rgbgb_front #(
	parameter int LINE_WIDTH = rgbgb_pkg::LINE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [rgbgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic [rgbgb_pkg::QCNT_W-1:0]       queue_count,
	output rgbgb_pkg::blur_push_t              push
);

	localparam int AW    = $clog2(LINE_WIDTH);
	localparam int TW    = (AW + 1 > rgbgb_pkg::COL_W + 1) ? AW + 1 : rgbgb_pkg::COL_W + 1;
	localparam int EW    = rgbgb_pkg::ENTRY_W;
	localparam int PW    = rgbgb_pkg::PIX_W;
	localparam int CW    = rgbgb_pkg::CH_W;
	localparam int OCC_W = rgbgb_pkg::QCNT_W + 1;

	logic [rgbgb_pkg::COL_W-1:0] in_col;
	logic [rgbgb_pkg::ROW_W-1:0] in_row;
	logic [PW-1:0]               in_pix;
	logic [TW-1:0]               in_tap [3];
	logic                        accept;

	logic                        clr_q;
	logic [AW-1:0]               clr_addr_q;

	logic                        vld_s1;
	logic                        result_s1;
	logic [PW-1:0]               pix_s1;
	logic [TW-1:0]               tap_s1 [3];
	logic [2:0]                  tapok_s1;

	logic [EW-1:0]               rd_data [3];
	logic [EW-1:0]               col_fwd [3];
	logic [EW-1:0]               mid_new;
	logic                        wr_s1;

	logic                        bp_vld_q;
	logic [TW-1:0]               bp_tap_q;
	logic [EW-1:0]               bp_data_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [EW-1:0]               ram_wdata;

	logic                        vld_s2;
	logic                        result_s2;
	logic [EW-1:0]               win_s2 [3];

	logic [OCC_W-1:0]            occupancy;

	assign in_col = s_axis_tdata[7:0];
	assign in_row = s_axis_tdata[17:8];
	assign in_pix = s_axis_tdata[41:18];

	// Taps for columns x-1, x and x+1. At column zero the left tap wraps to all ones,
	// which lies past the line end.
	assign in_tap[0] = TW'(in_col) - TW'(1);
	assign in_tap[1] = TW'(in_col);
	assign in_tap[2] = TW'(in_col) + TW'(1);

	// Queue entries plus results still in flight must never exceed the queue depth.
	assign occupancy = OCC_W'(queue_count) + OCC_W'(vld_s1 & result_s1)
		+ OCC_W'(vld_s2 & result_s2);
	assign s_axis_tready = !clr_q && (occupancy < OCC_W'(rgbgb_pkg::QUEUE_DEPTH));
	assign accept = s_axis_tvalid && s_axis_tready;

	// One copy of the column store per tap, all written alike.
	for (genvar k = 0; k < 3; k++) begin : g_tap_ram
		rgbgb_ram #(
			.WIDTH(EW),
			.DEPTH(LINE_WIDTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we),
			.waddr(ram_waddr),
			.wdata(ram_wdata),
			.raddr(in_tap[k][AW-1:0]),
			.rdata(rd_data[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(LINE_WIDTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			result_s1 <= 1'b0;
			vld_s2    <= 1'b0;
			result_s2 <= 1'b0;
			bp_vld_q  <= 1'b0;
		end else begin
			vld_s1    <= accept;
			result_s1 <= (in_row != '0) && (in_col != '0);
			vld_s2    <= vld_s1;
			result_s2 <= result_s1;
			if (wr_s1) begin
				bp_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= in_pix;
		for (int k = 0; k < 3; k++) begin
			tap_s1[k]   <= in_tap[k];
			tapok_s1[k] <= in_tap[k] < TW'(LINE_WIDTH);
		end
		if (wr_s1) begin
			bp_tap_q  <= tap_s1[1];
			bp_data_q <= mid_new;
		end
		win_s2[0] <= tapok_s1[0] ? col_fwd[0] : '0;
		win_s2[1] <= tapok_s1[1] ? mid_new : '0;
		win_s2[2] <= tapok_s1[2] ? col_fwd[2] : '0;
	end

	// The write of the item just ahead lands after this item's read, so it is
	// taken from the bypass register instead.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			col_fwd[k] = (bp_vld_q && bp_tap_q == tap_s1[k]) ? bp_data_q : rd_data[k];
		end
	end

	// Oldest line in the low bits: the column shifts down by one line.
	assign mid_new = {pix_s1, col_fwd[1][EW-1:2*PW], col_fwd[1][2*PW-1:PW]};
	assign wr_s1   = vld_s1 && tapok_s1[1];

	assign ram_we    = clr_q || wr_s1;
	assign ram_waddr = clr_q ? clr_addr_q : tap_s1[1][AW-1:0];
	assign ram_wdata = clr_q ? '0 : mid_new;

	function automatic logic [CW-1:0] blur_channel(input logic [EW-1:0] left,
		input logic [EW-1:0] mid, input logic [EW-1:0] right, input int ch);
		logic [CW+1:0] line_sum [3];
		logic [CW+3:0] total;
		for (int v = 0; v < 3; v++) begin
			line_sum[v] = (CW+2)'(left[v*PW + ch*CW +: CW])
				+ {1'b0, mid[v*PW + ch*CW +: CW], 1'b0}
				+ (CW+2)'(right[v*PW + ch*CW +: CW]);
		end
		total = (CW+4)'(line_sum[0]) + {1'b0, line_sum[1], 1'b0} + (CW+4)'(line_sum[2]);
		return total[CW+3:4];
	endfunction

	always_comb begin
		push.valid = vld_s2 && result_s2;
		for (int ch = 0; ch < rgbgb_pkg::CH_COUNT; ch++) begin
			push.pixel[ch*CW +: CW] = blur_channel(win_s2[0], win_s2[1], win_s2[2], ch);
		end
	end

endmodule

[hdl/rgbgb_fifo.sv]
`timescale 1ns / 1ps

module rgbgb_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rgbgb_pkg::blur_push_t            push,
	output logic [rgbgb_pkg::QCNT_W-1:0]     count,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [rgbgb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int DEPTH = rgbgb_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = rgbgb_pkg::QCNT_W;

	logic [rgbgb_pkg::PIX_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        pop;

	assign count         = count_q;
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tdata  = rgbgb_pkg::OUT_TDATA_W'(slot_q[rd_ptr_q]);
	assign pop           = m_axis_tvalid && m_axis_tready;

	// The front end holds back input so that a push always finds room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.valid) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.pixel;
		end
	end

endmodule

[hdl/rgb_gaussian_blur_3x3_row_buffer_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_axis    in   48     column [7:0], row [17:8], pixel_in [41:18], zero [47:42]
// m_axis    out  24     pixel_out [23:0]
//
// One pixel is accepted per clock while s_axis_tready is high; a blurred pixel
// passes stages 1 and 2 into the result queue and can leave on the next clock.
// A line store read for a column that the previous pixel wrote is bypassed from that write.
// After reset a clearing pass zeroes every line store address, with s_axis_tready
// low throughout.
// A four-entry result queue absorbs output stalls; outside the clearing pass,
// tready drops only when the queue together with the results still in flight would fill it.

module rgb_gaussian_blur_3x3_row_buffer_core #(
	parameter int LINE_WIDTH = rgbgb_pkg::LINE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// column [7:0], row [17:8], pixel_in [41:18], zero fill [47:42]
	input  logic [rgbgb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_out [23:0]
	output logic [rgbgb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	rgbgb_pkg::blur_push_t            push;
	logic [rgbgb_pkg::QCNT_W-1:0]     queue_count;

	rgbgb_front #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.queue_count  (queue_count),
		.push         (push)
	);

	rgbgb_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.count        (queue_count),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule
